>>> rtl/fke_pkg.sv
// ----------------------------------------------------------------------------
// fke_pkg
// Shared types and constants of the flow key extractor.
// ----------------------------------------------------------------------------
package fke_pkg;

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  NH_IPV4       = 8'd4;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  NH_IPV6       = 8'd41;

    localparam logic [5:0]  IPV4_MIN_HDR_LEN = 6'd20;
    localparam logic [5:0]  IPV6_HDR_LEN     = 6'd40;

    localparam logic [7:0]  ETHER_KEY_V4 = ETH_TYPE_IPV4[15:8];
    localparam logic [7:0]  ETHER_KEY_V6 = ETH_TYPE_IPV6[15:8];
    localparam logic [5:0]  KEY_LEN_V4   = 6'd13;
    localparam logic [5:0]  KEY_LEN_V6   = 6'd37;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_L3    = 2'd1,
        ST_NO_L4    = 2'd2,
        ST_TRUNC    = 2'd3
    } t_status;

    // parse outcome of one frame, queued between parser and output stage
    typedef struct packed {
        t_status      status;
        logic         is_v6;
        logic [63:0]  src_hi;
        logic [63:0]  src_lo;
        logic [63:0]  dst_hi;
        logic [63:0]  dst_lo;
        logic [15:0]  src_port;
        logic [15:0]  dst_port;
    } t_record;

endpackage

>>> rtl/fke_parser.sv
// ----------------------------------------------------------------------------
// fke_parser
// Byte-wide header walker: tracks offsets through Ethernet, IPv4/IPv6 and
// tunnels, captures outer addresses and inner ports, emits a record per frame.
// ----------------------------------------------------------------------------
module fke_parser #(
    parameter int MAX_NEST     = 4,
    parameter int OFFSET_WIDTH = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    output logic             o_rec_valid,
    output fke_pkg::t_record o_rec
);
    import fke_pkg::*;

    localparam int NW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
    localparam int OW = OFFSET_WIDTH;
    localparam logic [OW-1:0] OFF_MAX = {OW{1'b1}};

    typedef enum logic [2:0] {
        PH_ETH, PH_V4, PH_V6, PH_L4, PH_DONE, PH_ERR
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [OW-1:0]    r_off, n_off;
    logic [OW-1:0]    r_hstart, n_hstart;
    logic [5:0]       r_hlen, n_hlen;
    logic [7:0]       r_nproto, n_nproto;
    logic [NW-1:0]    r_nest, n_nest;
    logic [3:0][63:0] r_addr, n_addr;
    logic [1:0][15:0] r_port, n_port;
    logic             r_v6, n_v6;
    t_status          r_err, n_err;

    logic [OW-1:0] rel;
    logic [OW-1:0] rel_m8;
    logic          outer;
    logic          tunnel_ok;
    logic          proto_l4;
    logic [5:0]    ihl_len;

    assign rel       = r_off - r_hstart;
    assign rel_m8    = rel - OW'(8);
    assign outer     = (r_nest == '0);
    assign tunnel_ok = (int'(r_nest) + 1 < MAX_NEST);
    assign proto_l4  = (r_nproto == PROTO_TCP) || (r_nproto == PROTO_UDP);
    assign ihl_len   = (i_data_byte[3:0] < 4'd5) ? IPV4_MIN_HDR_LEN
                                                 : {i_data_byte[3:0], 2'b00};

    always_comb begin
        n_phase  = r_phase;
        n_hstart = r_hstart;
        n_hlen   = r_hlen;
        n_nproto = r_nproto;
        n_nest   = r_nest;
        n_addr   = r_addr;
        n_port   = r_port;
        n_v6     = r_v6;
        n_err    = r_err;
        n_off    = (r_off != OFF_MAX) ? r_off + OW'(1) : r_off;

        if (r_phase != PH_DONE && r_phase != PH_ERR) begin
            if (r_off == OFF_MAX) begin
                n_phase = PH_ERR;
                n_err   = ST_TRUNC;
            end else begin
                unique case (r_phase)
                    PH_ETH: begin
                        if (rel == OW'(12)) begin
                            n_nproto = i_data_byte;
                        end else if (rel == OW'(13)) begin
                            n_hstart = r_off + OW'(1);
                            if ({r_nproto, i_data_byte} == ETH_TYPE_IPV4) begin
                                n_phase = PH_V4;
                                n_hlen  = IPV4_MIN_HDR_LEN;
                            end else if ({r_nproto, i_data_byte} == ETH_TYPE_IPV6) begin
                                n_phase = PH_V6;
                                n_hlen  = IPV6_HDR_LEN;
                                n_v6    = 1'b1;
                            end else begin
                                n_phase = PH_ERR;
                                n_err   = ST_NO_L3;
                            end
                        end
                    end
                    PH_V4, PH_V6: begin
                        if (r_phase == PH_V4) begin
                            if (rel == '0) begin
                                n_hlen = ihl_len;
                            end
                            if (rel == OW'(9)) begin
                                n_nproto = i_data_byte;
                            end
                            if (outer && rel >= OW'(12) && rel < OW'(16)) begin
                                n_addr[1] = {r_addr[1][55:0], i_data_byte};
                            end
                            if (outer && rel >= OW'(16) && rel < OW'(20)) begin
                                n_addr[3] = {r_addr[3][55:0], i_data_byte};
                            end
                        end else begin
                            if (rel == OW'(6)) begin
                                n_nproto = i_data_byte;
                            end
                            if (outer && rel >= OW'(8) && rel < OW'(40)) begin
                                n_addr[rel_m8[4:3]] = {r_addr[rel_m8[4:3]][55:0],
                                                       i_data_byte};
                            end
                        end
                        if ({1'b0, rel} + (OW+1)'(1) == (OW+1)'(r_hlen)) begin
                            n_hstart = r_off + OW'(1);
                            if (proto_l4) begin
                                n_phase = PH_L4;
                                n_hlen  = IPV4_MIN_HDR_LEN;
                            end else if (r_nproto == NH_IPV4
                                         || (r_phase == PH_V6 && r_nproto == NH_IPV6)) begin
                                if (tunnel_ok) begin
                                    n_nest  = r_nest + NW'(1);
                                    n_phase = (r_nproto == NH_IPV4) ? PH_V4 : PH_V6;
                                    n_hlen  = (r_nproto == NH_IPV4) ? IPV4_MIN_HDR_LEN
                                                                    : IPV6_HDR_LEN;
                                end else begin
                                    n_phase  = PH_ERR;
                                    n_err    = ST_NO_L4;
                                    n_hstart = r_hstart;
                                end
                            end else begin
                                n_phase  = PH_ERR;
                                n_err    = ST_NO_L4;
                                n_hstart = r_hstart;
                            end
                        end
                    end
                    PH_L4: begin
                        if (rel < OW'(4)) begin
                            n_port[rel[1]] = {r_port[rel[1]][7:0], i_data_byte};
                            if (rel == OW'(3)) begin
                                n_phase = PH_DONE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        o_rec_valid     = i_accept && i_last_byte;
        o_rec.is_v6     = n_v6;
        o_rec.src_hi    = n_addr[0];
        o_rec.src_lo    = n_addr[1];
        o_rec.dst_hi    = n_addr[2];
        o_rec.dst_lo    = n_addr[3];
        o_rec.src_port  = n_port[0];
        o_rec.dst_port  = n_port[1];
        priority if (n_phase == PH_DONE) begin
            o_rec.status = ST_OK;
        end else if (n_phase == PH_ERR) begin
            o_rec.status = n_err;
        end else begin
            o_rec.status = ST_TRUNC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_phase  <= PH_ETH;
            r_off    <= '0;
            r_hstart <= '0;
            r_hlen   <= '0;
            r_nproto <= '0;
            r_nest   <= '0;
            r_addr   <= '0;
            r_port   <= '0;
            r_v6     <= 1'b0;
            r_err    <= ST_OK;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_off    <= n_off;
            r_hstart <= n_hstart;
            r_hlen   <= n_hlen;
            r_nproto <= n_nproto;
            r_nest   <= n_nest;
            r_addr   <= n_addr;
            r_port   <= n_port;
            r_v6     <= n_v6;
            r_err    <= n_err;
        end
    end

endmodule

>>> rtl/fke_queue.sv
// ----------------------------------------------------------------------------
// fke_queue
// Small record queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module fke_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  fke_pkg::t_record i_wr_rec,
    input  logic             i_rd,
    output logic             o_full,
    output logic             o_nonempty,
    output fke_pkg::t_record o_rd_rec
);
    import fke_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_record       r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          wr_en, rd_en;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign wr_en      = i_wr && !o_full;
    assign rd_en      = i_rd && o_nonempty;
    assign o_rd_rec   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wr_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> rtl/fke_output.sv
// ----------------------------------------------------------------------------
// fke_output
// Builds the flow key from a queued record and holds it until popped.
// ----------------------------------------------------------------------------
module fke_output (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rec_valid,
    input  fke_pkg::t_record i_rec,
    output logic             o_rec_take,
    input  logic             pop,
    output logic             empty,
    output logic [1:0]       o_status,
    output logic             o_is_ipv6,
    output logic [7:0]       o_ether_key_byte,
    output logic [63:0]      o_source_high,
    output logic [63:0]      o_source_low,
    output logic [63:0]      o_dest_high,
    output logic [63:0]      o_dest_low,
    output logic [15:0]      o_source_port,
    output logic [15:0]      o_dest_port,
    output logic [5:0]       o_key_length
);
    import fke_pkg::*;

    logic r_valid;
    logic ok;

    assign empty      = !r_valid;
    assign o_rec_take = i_rec_valid && (!r_valid || pop);
    assign ok         = (i_rec.status == ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rec_take) begin
            r_valid <= 1'b1;
        end else if (pop) begin
            r_valid <= 1'b0;
        end
    end

    // error results carry a status and nothing else
    always_ff @(posedge i_clk) begin
        if (o_rec_take) begin
            o_status         <= i_rec.status;
            o_is_ipv6        <= ok && i_rec.is_v6;
            o_ether_key_byte <= !ok ? 8'd0 : (i_rec.is_v6 ? ETHER_KEY_V6 : ETHER_KEY_V4);
            o_key_length     <= !ok ? 6'd0 : (i_rec.is_v6 ? KEY_LEN_V6 : KEY_LEN_V4);
            o_source_high    <= ok ? i_rec.src_hi : 64'd0;
            o_source_low     <= ok ? i_rec.src_lo : 64'd0;
            o_dest_high      <= ok ? i_rec.dst_hi : 64'd0;
            o_dest_low       <= ok ? i_rec.dst_lo : 64'd0;
            o_source_port    <= ok ? i_rec.src_port : 16'd0;
            o_dest_port      <= ok ? i_rec.dst_port : 16'd0;
        end
    end

endmodule

>>> rtl/flow_key_extractor.sv
// ----------------------------------------------------------------------------
// flow_key_extractor
// Five-tuple flow key extraction from a byte-serial Ethernet frame.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock while full is low, with no gaps required;
// every byte is handled in the cycle it is accepted, so frames stream back to
// back at one byte per cycle. The byte flagged last produces one key item (or
// an error status) that is written to a QUEUE_DEPTH-entry queue at the edge
// that accepts that byte and passes from the queue into the output register,
// which drives the result ports, once that register is free. full rises only
// when the queue holds QUEUE_DEPTH undelivered items and the output register
// is also occupied. Offsets are tracked in OFFSET_WIDTH bits; a frame that
// outruns that range before its ports are seen reports truncated. Tunnels are
// followed up to MAX_NEST network headers in total.
module flow_key_extractor #(
    parameter int MAX_NEST     = 4,
    parameter int OFFSET_WIDTH = 11,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic        o_is_ipv6,
    output logic [7:0]  o_ether_key_byte,
    output logic [63:0] o_source_high,
    output logic [63:0] o_source_low,
    output logic [63:0] o_dest_high,
    output logic [63:0] o_dest_low,
    output logic [15:0] o_source_port,
    output logic [15:0] o_dest_port,
    output logic [5:0]  o_key_length
);
    import fke_pkg::*;

    logic    accept;
    logic    parse_rec_valid;
    t_record parse_rec;
    logic    q_nonempty;
    t_record q_rec;
    logic    q_take;

    assign accept = push && !full;

    fke_parser #(
        .MAX_NEST     (MAX_NEST),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_rec_valid (parse_rec_valid),
        .o_rec       (parse_rec)
    );

    fke_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (parse_rec_valid),
        .i_wr_rec   (parse_rec),
        .i_rd       (q_take),
        .o_full     (full),
        .o_nonempty (q_nonempty),
        .o_rd_rec   (q_rec)
    );

    fke_output u_output (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rec_valid      (q_nonempty),
        .i_rec            (q_rec),
        .o_rec_take       (q_take),
        .pop              (pop),
        .empty            (empty),
        .o_status         (o_status),
        .o_is_ipv6        (o_is_ipv6),
        .o_ether_key_byte (o_ether_key_byte),
        .o_source_high    (o_source_high),
        .o_source_low     (o_source_low),
        .o_dest_high      (o_dest_high),
        .o_dest_low       (o_dest_low),
        .o_source_port    (o_source_port),
        .o_dest_port      (o_dest_port),
        .o_key_length     (o_key_length)
    );

endmodule

>>> rtl/fke_checker.sv
// ----------------------------------------------------------------------------
// fke_checker
// Port-level checks on the result items of the flow key extractor.
// ----------------------------------------------------------------------------
module fke_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic [1:0]  o_status,
    input logic        o_is_ipv6,
    input logic [7:0]  o_ether_key_byte,
    input logic [63:0] o_source_high,
    input logic [63:0] o_source_low,
    input logic [63:0] o_dest_high,
    input logic [63:0] o_dest_low,
    input logic [15:0] o_source_port,
    input logic [15:0] o_dest_port,
    input logic [5:0]  o_key_length
);
    import fke_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("result side not cleared by reset");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status != ST_OK |->
            o_key_length == 6'd0 && !o_is_ipv6 && o_ether_key_byte == 8'd0
            && o_source_port == 16'd0 && o_dest_port == 16'd0
            && o_source_low == 64'd0 && o_dest_low == 64'd0)
        else $error("error item carries key fields");

    a_ok_v6: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status == ST_OK && o_is_ipv6 |->
            o_key_length == KEY_LEN_V6 && o_ether_key_byte == ETHER_KEY_V6)
        else $error("IPv6 key mislabeled");

    a_ok_v4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status == ST_OK && !o_is_ipv6 |->
            o_key_length == KEY_LEN_V4 && o_ether_key_byte == ETHER_KEY_V4
            && o_source_high == 64'd0 && o_dest_high == 64'd0
            && o_source_low[63:32] == 32'd0 && o_dest_low[63:32] == 32'd0)
        else $error("IPv4 key mislabeled or wide address");

endmodule

bind flow_key_extractor fke_checker u_fke_checker (.*);

>>> verif/tb_flow_key_extractor.sv
// ----------------------------------------------------------------------------
// tb_flow_key_extractor
// Self-checking testbench for the flow key extractor.
// ----------------------------------------------------------------------------
// Frames are built from a compact description (ethertype, header chain, IHL,
// transport protocol, truncation, trailing bytes, fill pattern) and streamed
// one byte per push item. A built-in predictor tracks the parse byte by byte
// and queues the key expected at each last byte. Idle gaps are random on both
// sides. Directed edge cases go first; short frames then meet a long receiver
// stall and a drain, then mostly well formed random frames and a drain.
// ----------------------------------------------------------------------------
module tb_flow_key_extractor;

    timeunit 1ns;
    timeprecision 1ps;

    import fke_pkg::*;

    localparam int MAX_NEST       = 4;
    localparam int OFFSET_WIDTH   = 11;
    localparam int OFF_MAX        = (1 << OFFSET_WIDTH) - 1;
    localparam int ITEMS          = 1950;
    localparam int PRESSURE_KEYS  = 30;
    localparam int RX_HOLD        = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum logic [2:0] {
        PH_ETH, PH_V4, PH_V6, PH_L4, PH_DONE, PH_ERR
    } t_phase;

    typedef enum logic [1:0] {
        OUTER_NONE, OUTER_V4, OUTER_V6
    } t_outer;

    typedef enum logic [1:0] {
        FILL_RAND, FILL_ZERO, FILL_ONES
    } t_fill;

    typedef struct packed {
        t_status      status;
        logic         is_v6;
        logic [7:0]   ether;
        logic [63:0]  src_hi;
        logic [63:0]  src_lo;
        logic [63:0]  dst_hi;
        logic [63:0]  dst_lo;
        logic [15:0]  src_port;
        logic [15:0]  dst_port;
        logic [5:0]   key_len;
    } t_flow_key;

    // hdr_v6 bit h set: network header h is IPv6
    typedef struct packed {
        logic [15:0]  ether;
        int           n_hdr;
        logic [4:0]   hdr_v6;
        logic [3:0]   ihl;
        logic [7:0]   l4_proto;
        int           cut;
        int           trail;
        t_fill        fill;
        logic         typed;
        t_status      typed_status;
    } t_frame;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        empty;
    logic        pop;
    logic [1:0]  o_status;
    logic        o_is_ipv6;
    logic [7:0]  o_ether_key_byte;
    logic [63:0] o_source_high;
    logic [63:0] o_source_low;
    logic [63:0] o_dest_high;
    logic [63:0] o_dest_low;
    logic [15:0] o_source_port;
    logic [15:0] o_dest_port;
    logic [5:0]  o_key_length;

    flow_key_extractor #(
        .MAX_NEST     (MAX_NEST),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .empty            (empty),
        .pop              (pop),
        .o_status         (o_status),
        .o_is_ipv6        (o_is_ipv6),
        .o_ether_key_byte (o_ether_key_byte),
        .o_source_high    (o_source_high),
        .o_source_low     (o_source_low),
        .o_dest_high      (o_dest_high),
        .o_dest_low       (o_dest_low),
        .o_source_port    (o_source_port),
        .o_dest_port      (o_dest_port),
        .o_key_length     (o_key_length)
    );

    // predictor state
    int          cur_off;
    t_phase      cur_phase;
    int          hdr_base;
    int          hdr_len;
    logic [7:0]  proto_sel;
    int          tunnel_depth;
    logic [63:0] addr_acc [4];
    logic [15:0] port_acc [2];
    t_outer      outer_kind;
    t_status     err_status;

    t_flow_key   pending_keys [$];
    logic [7:0]  frame_bytes [$];
    int          bytes_sent;
    int          mismatches;
    bit          rst_done;
    bit          tx_burst;
    bit          rx_burst;
    int          hold_requests;
    int          holds_served;

    //   ether           hdrs v6 mask   ihl    l4 proto    cut trl fill       typed status
    t_frame directed_frames [24] = '{
        '{ETH_TYPE_IPV4, 1, 5'b00000, 4'd5,  PROTO_TCP, 1,  0,  FILL_RAND, 1'b1, ST_TRUNC},
        '{16'hFFFF,      1, 5'b00000, 4'd5,  PROTO_TCP, 14, 0,  FILL_ONES, 1'b1, ST_NO_L3},
        '{16'h0000,      1, 5'b00000, 4'd5,  PROTO_TCP, 14, 0,  FILL_ZERO, 1'b1, ST_NO_L3},
        '{16'h86DC,      1, 5'b00001, 4'd5,  PROTO_UDP, 0,  0,  FILL_RAND, 1'b1, ST_NO_L3},
        '{ETH_TYPE_IPV4, 1, 5'b00000, 4'd5,  PROTO_TCP, 0,  0,  FILL_RAND, 1'b0, ST_OK},
        '{ETH_TYPE_IPV4, 1, 5'b00000, 4'd0,  PROTO_UDP, 0,  0,  FILL_ZERO, 1'b0, ST_OK},
        '{ETH_TYPE_IPV4, 1, 5'b00000, 4'd15, PROTO_TCP, 0,  0,  FILL_ONES, 1'b0, ST_OK},
        '{ETH_TYPE_IPV6, 1, 5'b00001, 4'd5,  PROTO_TCP, 0,  0,  FILL_RAND, 1'b0, ST_OK},
        '{ETH_TYPE_IPV6, 1, 5'b00001, 4'd5,  PROTO_UDP, 0,  0,  FILL_ONES, 1'b0, ST_OK},
        '{ETH_TYPE_IPV4, 1, 5'b00000, 4'd5,  8'd1,      0,  0,  FILL_RAND, 1'b1, ST_NO_L4},
        '{ETH_TYPE_IPV6, 1, 5'b00001, 4'd5,  8'd0,      0,  0,  FILL_RAND, 1'b1, ST_NO_L4},
        '{ETH_TYPE_IPV6, 1, 5'b00001, 4'd5,  8'hFF,     0,  0,  FILL_ONES, 1'b1, ST_NO_L4},
        '{ETH_TYPE_IPV4, 2, 5'b00000, 4'd6,  PROTO_UDP, 0,  0,  FILL_RAND, 1'b0, ST_OK},
        '{ETH_TYPE_IPV6, 2, 5'b00001, 4'd5,  PROTO_TCP, 0,  0,  FILL_RAND, 1'b0, ST_OK},
        '{ETH_TYPE_IPV6, 2, 5'b00011, 4'd5,  PROTO_UDP, 0,  0,  FILL_RAND, 1'b0, ST_OK},
        '{ETH_TYPE_IPV4, 2, 5'b00010, 4'd5,  PROTO_TCP, 0,  0,  FILL_RAND, 1'b1, ST_NO_L4},
        '{ETH_TYPE_IPV6, 4, 5'b01111, 4'd5,  PROTO_UDP, 0,  0,  FILL_RAND, 1'b0, ST_OK},
        '{ETH_TYPE_IPV6, 5, 5'b11111, 4'd5,  PROTO_TCP, 0,  0,  FILL_RAND, 1'b1, ST_NO_L4},
        '{ETH_TYPE_IPV4, 5, 5'b00000, 4'd5,  PROTO_UDP, 0,  0,  FILL_RAND, 1'b1, ST_NO_L4},
        '{ETH_TYPE_IPV4, 1, 5'b00000, 4'd5,  PROTO_TCP, 36, 0,  FILL_RAND, 1'b1, ST_TRUNC},
        '{ETH_TYPE_IPV6, 1, 5'b00001, 4'd5,  PROTO_UDP, 30, 0,  FILL_RAND, 1'b1, ST_TRUNC},
        '{ETH_TYPE_IPV4, 1, 5'b00000, 4'd5,  PROTO_UDP, 0,  12, FILL_RAND, 1'b0, ST_OK},
        '{ETH_TYPE_IPV4, 1, 5'b00000, 4'd5,  8'd1,      0,  9,  FILL_RAND, 1'b1, ST_NO_L4},
        '{ETH_TYPE_IPV4, 1, 5'b00000, 4'd5,  PROTO_TCP, 13, 0,  FILL_RAND, 1'b1, ST_TRUNC}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void key_clear();
        cur_off      = 0;
        cur_phase    = PH_ETH;
        hdr_base     = 0;
        hdr_len      = 0;
        proto_sel    = '0;
        tunnel_depth = 0;
        for (int i = 0; i < 4; i++) addr_acc[i] = '0;
        port_acc[0]  = '0;
        port_acc[1]  = '0;
        outer_kind   = OUTER_NONE;
        err_status   = ST_OK;
    endfunction

    function automatic void key_fail(t_status s);
        cur_phase  = PH_ERR;
        err_status = s;
    endfunction

    function automatic void key_enter(t_phase ph, bit tunnel);
        if (tunnel) begin
            if (tunnel_depth + 1 >= MAX_NEST) begin
                key_fail(ST_NO_L4);
                return;
            end
            tunnel_depth++;
        end
        cur_phase = ph;
        hdr_base  = cur_off + 1;
        hdr_len   = (ph == PH_V6) ? int'(IPV6_HDR_LEN) : int'(IPV4_MIN_HDR_LEN);
    endfunction

    function automatic void key_next_layer(bit from_v6);
        if (proto_sel == PROTO_TCP || proto_sel == PROTO_UDP)
            key_enter(PH_L4, 1'b0);
        else if (proto_sel == NH_IPV4)
            key_enter(PH_V4, 1'b1);
        else if (from_v6 && proto_sel == NH_IPV6)
            key_enter(PH_V6, 1'b1);
        else
            key_fail(ST_NO_L4);
    endfunction

    function automatic void key_parse(logic [7:0] b);
        int rel;
        int idx;
        int ihl;
        bit outer;
        rel   = (cur_off - hdr_base) & OFF_MAX;
        outer = (tunnel_depth == 0);
        case (cur_phase)
            PH_ETH: begin
                if (rel == 12) begin
                    proto_sel = b;
                end else if (rel == 13) begin
                    if ({proto_sel, b} == ETH_TYPE_IPV4) begin
                        outer_kind = OUTER_V4;
                        key_enter(PH_V4, 1'b0);
                    end else if ({proto_sel, b} == ETH_TYPE_IPV6) begin
                        outer_kind = OUTER_V6;
                        key_enter(PH_V6, 1'b0);
                    end else begin
                        key_fail(ST_NO_L3);
                    end
                end
            end
            PH_V4: begin
                if (rel == 0) begin
                    ihl = int'(b[3:0]);
                    if (ihl < 5) ihl = 5;
                    hdr_len = ihl * 4;
                end
                if (rel == 9) proto_sel = b;
                if (outer && rel >= 12 && rel < 16) addr_acc[1] = {addr_acc[1][55:0], b};
                if (outer && rel >= 16 && rel < 20) addr_acc[3] = {addr_acc[3][55:0], b};
                if (rel + 1 == hdr_len) key_next_layer(1'b0);
            end
            PH_V6: begin
                if (rel == 6) proto_sel = b;
                if (outer && rel >= 8 && rel < 40) begin
                    idx = (rel - 8) >> 3;
                    addr_acc[idx] = {addr_acc[idx][55:0], b};
                end
                if (rel + 1 == int'(IPV6_HDR_LEN)) key_next_layer(1'b1);
            end
            PH_L4: begin
                if (rel < 4) begin
                    idx = rel >> 1;
                    port_acc[idx] = {port_acc[idx][7:0], b};
                    if (rel == 3) cur_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // returns 1 when the byte closes a frame and key holds its result
    function automatic bit key_predict(logic [7:0] b, bit is_last, output t_flow_key key);
        bit v6;
        key = '0;
        if (cur_phase != PH_DONE && cur_phase != PH_ERR) begin
            if (cur_off >= OFF_MAX)
                key_fail(ST_TRUNC);
            else
                key_parse(b);
        end
        if (cur_off < OFF_MAX) cur_off++;
        if (!is_last) return 1'b0;
        if (cur_phase == PH_DONE) begin
            v6           = (outer_kind == OUTER_V6);
            key.status   = ST_OK;
            key.is_v6    = v6;
            key.ether    = v6 ? ETHER_KEY_V6 : ETHER_KEY_V4;
            key.src_hi   = addr_acc[0];
            key.src_lo   = addr_acc[1];
            key.dst_hi   = addr_acc[2];
            key.dst_lo   = addr_acc[3];
            key.src_port = port_acc[0];
            key.dst_port = port_acc[1];
            key.key_len  = v6 ? KEY_LEN_V6 : KEY_LEN_V4;
        end else if (cur_phase == PH_ERR) begin
            key.status = err_status;
        end else begin
            key.status = ST_TRUNC;
        end
        key_clear();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // frame construction
    // ------------------------------------------------------------------
    function automatic logic [7:0] fill_byte(t_fill mode);
        case (mode)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void build_frame(t_frame f);
        logic [7:0] nxt;
        logic [7:0] b0;
        int         len;
        frame_bytes.delete();
        for (int i = 0; i < 12; i++) frame_bytes.push_back(fill_byte(f.fill));
        frame_bytes.push_back(f.ether[15:8]);
        frame_bytes.push_back(f.ether[7:0]);
        for (int h = 0; h < f.n_hdr; h++) begin
            if (h == f.n_hdr - 1)
                nxt = f.l4_proto;
            else
                nxt = f.hdr_v6[h + 1] ? NH_IPV6 : NH_IPV4;
            if (f.hdr_v6[h]) begin
                for (int k = 0; k < 40; k++)
                    frame_bytes.push_back((k == 6) ? nxt : fill_byte(f.fill));
            end else begin
                b0      = fill_byte(f.fill);
                b0[3:0] = f.ihl;
                len     = ((f.ihl < 5) ? 5 : int'(f.ihl)) * 4;
                for (int k = 0; k < len; k++) begin
                    if (k == 0)
                        frame_bytes.push_back(b0);
                    else if (k == 9)
                        frame_bytes.push_back(nxt);
                    else
                        frame_bytes.push_back(fill_byte(f.fill));
                end
            end
        end
        for (int k = 0; k < 4; k++) frame_bytes.push_back(fill_byte(f.fill));
        while (f.cut > 0 && frame_bytes.size() > f.cut) void'(frame_bytes.pop_back());
        for (int k = 0; k < f.trail; k++) frame_bytes.push_back(fill_byte(f.fill));
    endfunction

    function automatic t_frame random_frame();
        t_frame f;
        int     r;
        f = '0;
        r = $urandom_range(0, 99);
        f.n_hdr = (r < 50) ? 1 : (r < 75) ? 2 : (r < 88) ? 3 : (r < 96) ? 4 : 5;
        f.hdr_v6[0] = 1'($urandom_range(0, 1));
        for (int h = 1; h < 5; h++)
            f.hdr_v6[h] = f.hdr_v6[h - 1] ? 1'($urandom_range(0, 1)) : 1'b0;
        f.ether    = f.hdr_v6[0] ? ETH_TYPE_IPV6 : ETH_TYPE_IPV4;
        f.ihl      = 4'($urandom_range(0, 15));
        f.l4_proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
        f.trail    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 0;
        r = $urandom_range(0, 99);
        f.fill = (r < 5) ? FILL_ZERO : (r < 10) ? FILL_ONES : FILL_RAND;
        // broken frames
        r = $urandom_range(0, 99);
        if (r < 5)
            f.ether = 16'($urandom_range(0, 65535));
        else if (r < 10)
            f.l4_proto = 8'($urandom_range(0, 255));
        else if (r < 14)
            f.hdr_v6 = 5'($urandom_range(0, 31));
        else if (r < 22)
            f.cut = $urandom_range(1, 18 + 40 * f.n_hdr);
        return f;
    endfunction

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic put_byte(logic [7:0] b, bit is_last);
        int gap;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= is_last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic send_frame(t_frame f);
        t_flow_key key;
        bit        is_last;
        build_frame(f);
        foreach (frame_bytes[i]) begin
            is_last = (i == frame_bytes.size() - 1);
            put_byte(frame_bytes[i], is_last);
            bytes_sent++;
            if (key_predict(frame_bytes[i], is_last, key)) begin
                if (f.typed) begin
                    key        = '0;
                    key.status = f.typed_status;
                end
                pending_keys.push_back(key);
            end
        end
    endtask

    task automatic tx_drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_keys.size() != 0);
    endtask

    initial begin
        t_frame f;
        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        i_data_byte   <= '0;
        i_last_byte   <= 1'b0;
        bytes_sent    = 0;
        mismatches    = 0;
        rst_done      = 1'b0;
        tx_burst      = 1'b0;
        rx_burst      = 1'b0;
        hold_requests = 0;
        key_clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        foreach (directed_frames[i]) send_frame(directed_frames[i]);

        // receiver stalls while short frames pile up behind it
        tx_burst = 1'b1;
        hold_requests++;
        for (int i = 0; i < PRESSURE_KEYS; i++) begin
            f          = '0;
            f.ether    = ETH_TYPE_IPV4;
            f.n_hdr    = 1;
            f.ihl      = 4'd5;
            f.l4_proto = PROTO_TCP;
            f.cut      = $urandom_range(1, 3);
            send_frame(f);
        end
        tx_burst = 1'b0;
        tx_drain();

        while (bytes_sent < ITEMS) begin
            f = random_frame();
            tx_burst = ($urandom_range(0, 4) == 0);
            send_frame(f);
        end
        tx_burst = 1'b0;
        tx_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb_flow_key_extractor OK");
        else
            $display("tb_flow_key_extractor NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------
    function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic check_key();
        t_flow_key want;
        bit        ok;
        if (pending_keys.size() == 0) begin
            $display("%0t: unexpected item: status %h", $time, o_status);
            mismatches++;
            return;
        end
        want = pending_keys.pop_front();
        ok = 1'b1;
        ok &= field_ok("status", 64'(want.status), 64'(o_status));
        ok &= field_ok("is_ipv6", 64'(want.is_v6), 64'(o_is_ipv6));
        ok &= field_ok("ether_key_byte", 64'(want.ether), 64'(o_ether_key_byte));
        ok &= field_ok("source_high", want.src_hi, o_source_high);
        ok &= field_ok("source_low", want.src_lo, o_source_low);
        ok &= field_ok("dest_high", want.dst_hi, o_dest_high);
        ok &= field_ok("dest_low", want.dst_lo, o_dest_low);
        ok &= field_ok("source_port", 64'(want.src_port), 64'(o_source_port));
        ok &= field_ok("dest_port", 64'(want.dst_port), 64'(o_dest_port));
        ok &= field_ok("key_length", 64'(want.key_len), 64'(o_key_length));
        if (!ok) mismatches++;
    endtask

    initial begin
        int idle;
        pop          <= 1'b0;
        holds_served = 0;
        while (!rst_done) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 59) == 0) rx_burst = !rx_burst;
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                idle = RX_HOLD;
            end else begin
                idle = rx_burst ? 0 : pick_gap();
            end
            if (idle > 0) begin
                pop <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            if (!empty) check_key();
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_flow_key_extractor NOT OK");
        $finish;
    end

endmodule
